// File: hw/rtl/sukt_pkg.sv
// Shared types and codes for the sorted unique key table.
`default_nettype none

package sukt_pkg;

    localparam int OP_W  = 3;
    localparam int KEY_W = 32;
    localparam int ST_W  = 3;
    localparam int POS_W = 6;

    localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE    = 3'd1;
    localparam logic [OP_W-1:0] OP_SEARCH    = 3'd2;
    localparam logic [OP_W-1:0] OP_LIST_ASC  = 3'd3;
    localparam logic [OP_W-1:0] OP_LIST_DESC = 3'd4;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_DUP      = 3'd1;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic            load;
        logic            do_insert;
        logic            do_remove;
        logic            list_start;
        logic            list_step;
        logic            list_desc;
        logic            emit;
        logic            with_key;
        logic [ST_W-1:0] status;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic full;
        logic hit;
        logic list_done;
    } stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/sukt_ctrl.sv
// Controller state machine of the sorted unique key table.
`default_nettype none

module sukt_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [sukt_pkg::OP_W-1:0]  op,
    input  wire sukt_pkg::stat_t            stat,
    output sukt_pkg::cmd_t                  cmd,
    output logic                            busy
);
    import sukt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_APPLY = 3'b010,
        S_LIST  = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    logic [OP_W-1:0] op_reg, op_next;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                // Unused op codes are dropped without leaving idle.
                if (start && op <= OP_LIST_DESC)
                begin
                    cmd.load   = 1'b1;
                    op_next    = op;
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                state_next = S_IDLE;
                case (op_reg)
                    OP_INSERT:
                    begin
                        cmd.emit = 1'b1;
                        if (stat.hit)
                        begin
                            cmd.status = ST_DUP;
                        end
                        else if (stat.full)
                        begin
                            cmd.status = ST_FULL;
                        end
                        else
                        begin
                            cmd.status    = ST_OK;
                            cmd.do_insert = 1'b1;
                        end
                    end
                    OP_DELETE, OP_SEARCH:
                    begin
                        cmd.emit = 1'b1;
                        if (stat.empty)
                        begin
                            cmd.status = ST_EMPTY;
                        end
                        else if (!stat.hit)
                        begin
                            cmd.status = ST_NOTFOUND;
                        end
                        else
                        begin
                            cmd.status = ST_OK;
                            if (op_reg == OP_DELETE)
                            begin
                                cmd.do_remove = 1'b1;
                            end
                            else
                            begin
                                cmd.with_key = 1'b1;
                            end
                        end
                    end
                    OP_LIST_ASC, OP_LIST_DESC:
                    begin
                        if (stat.empty)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.status = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.list_start = 1'b1;
                            state_next     = S_LIST;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_LIST:
            begin
                cmd.list_step = 1'b1;
                cmd.list_desc = (op_reg == OP_LIST_DESC);
                if (stat.list_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_INSERT;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

`ifndef SYNTH
    a_accept_to_apply: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start && op <= OP_LIST_DESC) |=> (state_reg == S_APPLY))
        else $error("valid transaction did not move the controller to apply");

    a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_insert |-> (!stat.full && !stat.hit))
        else $error("insert issued into a full table or over a duplicate");

    a_single_edit: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.do_insert && cmd.do_remove) && !(cmd.emit && cmd.list_step))
        else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/sukt_datapath.sv
// Cell chain, compare flags, listing counters and result registers of the key table.
`default_nettype none

module sukt_datapath #(
    parameter int TABLE_DEPTH = 32,
    parameter int KEY_BITS    = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic signed [sukt_pkg::KEY_W-1:0]  key,
    input  wire sukt_pkg::cmd_t                     cmd,
    output sukt_pkg::stat_t                         stat,
    output logic                                    strobe,
    output logic [sukt_pkg::ST_W-1:0]               status,
    output logic signed [sukt_pkg::KEY_W-1:0]       key_out,
    output logic [sukt_pkg::POS_W-1:0]              position,
    output logic                                    last
);
    import sukt_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int KW = $clog2(TABLE_DEPTH);

    logic signed [KEY_BITS-1:0] cells_reg  [TABLE_DEPTH];
    logic signed [KEY_BITS-1:0] cells_next [TABLE_DEPTH];
    logic signed [KEY_BITS-1:0] key_reg;
    logic signed [KEY_BITS-1:0] key_n;
    logic [TABLE_DEPTH-1:0]     lt_reg, lt_next, eq_reg, eq_next, lt_prev;
    logic [CW-1:0]              count_reg, count_next;
    logic [KW-1:0]              k_reg, k_next;
    logic [CW-1:0]              pos_reg, pos_next;
    logic                       in_win;

    logic                       strobe_reg, strobe_next;
    logic [ST_W-1:0]            status_reg, status_next;
    logic signed [KEY_W-1:0]    key_out_reg, key_out_next;
    logic [POS_W-1:0]           position_reg, position_next;
    logic                       last_reg, last_next;

    // Keys are stored at KEY_BITS: truncated or sign-extended.
    assign key_n = KEY_BITS'(key);

    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            lt_next[i] = (CW'(i) < count_reg) && (cells_reg[i] < key_n);
            eq_next[i] = (CW'(i) < count_reg) && (cells_reg[i] == key_n);
        end
    end

    assign lt_prev = {lt_reg[TABLE_DEPTH-2:0], 1'b1};

    // Each cell looks only at its two neighbors. Listing rotates the whole
    // chain once around, so the contents are back in place at the end.
    always_comb
    begin
        int prv;
        int nxt;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            prv = (i == 0) ? TABLE_DEPTH - 1 : i - 1;
            nxt = (i == TABLE_DEPTH - 1) ? 0 : i + 1;
            cells_next[i] = cells_reg[i];
            if (cmd.do_insert)
            begin
                if (!lt_reg[i])
                begin
                    cells_next[i] = lt_prev[i] ? key_reg : cells_reg[prv];
                end
            end
            else if (cmd.do_remove)
            begin
                if (!lt_reg[i] && i != TABLE_DEPTH - 1)
                begin
                    cells_next[i] = cells_reg[nxt];
                end
            end
            else if (cmd.list_step)
            begin
                cells_next[i] = cmd.list_desc ? cells_reg[prv] : cells_reg[nxt];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            cells_reg[i] <= cells_next[i];
        end
        if (cmd.load)
        begin
            key_reg <= key_n;
        end
    end

    // Descending reads the top cell while rotating right; it shows the
    // stored keys once the rotation has passed the unused cells.
    always_comb
    begin
        if (cmd.list_desc)
        begin
            in_win = ((CW + 1)'(k_reg) + (CW + 1)'(count_reg)) >= (CW + 1)'(TABLE_DEPTH);
        end
        else
        begin
            in_win = CW'(k_reg) < count_reg;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        k_next     = k_reg;
        pos_next   = pos_reg;
        if (cmd.do_insert)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.do_remove)
        begin
            count_next = count_reg - CW'(1);
        end
        if (cmd.list_start)
        begin
            k_next   = '0;
            pos_next = '0;
        end
        else if (cmd.list_step)
        begin
            k_next = k_reg + KW'(1);
            if (in_win)
            begin
                pos_next = pos_reg + CW'(1);
            end
        end
    end

    always_comb
    begin
        strobe_next   = cmd.emit || (cmd.list_step && in_win);
        status_next   = ST_OK;
        key_out_next  = '0;
        position_next = '0;
        last_next     = 1'b1;
        if (cmd.emit)
        begin
            status_next = cmd.status;
            if (cmd.with_key)
            begin
                key_out_next = KEY_W'(key_reg);
            end
        end
        else
        begin
            key_out_next  = cmd.list_desc ? KEY_W'(cells_reg[TABLE_DEPTH-1])
                                          : KEY_W'(cells_reg[0]);
            position_next = POS_W'(pos_reg + CW'(1));
            last_next     = ((pos_reg + CW'(1)) == count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            k_reg      <= '0;
            pos_reg    <= '0;
            lt_reg     <= '0;
            eq_reg     <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            k_reg      <= k_next;
            pos_reg    <= pos_next;
            strobe_reg <= strobe_next;
            if (cmd.load)
            begin
                lt_reg <= lt_next;
                eq_reg <= eq_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        key_out_reg  <= key_out_next;
        position_reg <= position_next;
        last_reg     <= last_next;
    end

    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg == CW'(TABLE_DEPTH));
    assign stat.hit       = |eq_reg;
    assign stat.list_done = (k_reg == KW'(TABLE_DEPTH - 1));

    assign strobe   = strobe_reg;
    assign status   = status_reg;
    assign key_out  = key_out_reg;
    assign position = position_reg;
    assign last     = last_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(eq_reg))
        else $error("more than one cell matches the key");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_insert |=> (count_reg == CW'($past(count_reg) + CW'(1))))
        else $error("insert did not grow the table by one");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/sorted_unique_key_table.sv
// Top level of the sorted unique key table: controller plus cell-chain datapath.
// Insert, delete and search: the result strobe is registered from the apply state after
// the accepting edge; busy is high for one cycle and the next start waits until it falls.
// List: busy until the chain has rotated once fully around, giving
// one result per stored key; listing an empty table behaves like a search.
// Unused op codes are dropped in idle and give no result. The receiver cannot stall.
// Reset clears the entry count and control state; cell contents stay undefined.
`default_nettype none

module sorted_unique_key_table #(
    parameter int TABLE_DEPTH = 32,
    parameter int KEY_BITS    = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [sukt_pkg::OP_W-1:0]          op,
    input  wire logic signed [sukt_pkg::KEY_W-1:0]  key,
    output logic                                    strobe,
    output logic [sukt_pkg::ST_W-1:0]               status,
    output logic signed [sukt_pkg::KEY_W-1:0]       key_out,
    output logic [sukt_pkg::POS_W-1:0]              position,
    output logic                                    last
);
    import sukt_pkg::*;

    // The controller decodes the op code once the compare flags are in
    // place and issues one command per cycle to the datapath.
    cmd_t  cmd;
    stat_t stat;

    // A transaction is taken when start meets an idle controller. On that
    // edge the datapath compares the key against every occupied cell in
    // parallel and registers a less-than and an equal flag per cell.
    sukt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // In the apply cycle each cell either holds, takes the new key, or
    // takes a neighbor's key, so insert and delete finish in one step.
    // Listing rotates the chain and reads the keys at a fixed end cell;
    // after a full turn the table is back in its sorted order.
    sukt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .key      (key),
        .cmd      (cmd),
        .stat     (stat),
        .strobe   (strobe),
        .status   (status),
        .key_out  (key_out),
        .position (position),
        .last     (last)
    );

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the sorted unique key table.
`timescale 1ns / 1ps

module tb;

    import sukt_pkg::*;

    localparam int TABLE_DEPTH = 32;
    localparam int KEY_POOL_SIZE = 40;
    localparam int RANDOM_COMMANDS = 380;

    // One command transaction as it waits in the driver queue.
    typedef struct {
        logic [OP_W-1:0]         code;
        logic signed [KEY_W-1:0] value;
    } command_t;

    // One result as the table model predicts it.
    typedef struct {
        logic [ST_W-1:0]         st;
        logic signed [KEY_W-1:0] k;
        logic [POS_W-1:0]        pos;
        logic                    fin;
    } reply_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [OP_W-1:0] op = '0;
    logic signed [KEY_W-1:0] key = '0;
    logic busy;
    logic strobe;
    logic [ST_W-1:0] status;
    logic signed [KEY_W-1:0] key_out;
    logic [POS_W-1:0] position;
    logic last;

    command_t pending_commands[$];
    reply_t expected_replies[$];

    // Model of the table contents: entries 0 .. stored_count-1, ascending.
    logic signed [KEY_W-1:0] model_keys [0:TABLE_DEPTH-1];
    int stored_count = 0;

    // Keys drawn for insert, delete and search so that hits and a full table occur.
    logic signed [KEY_W-1:0] key_pool [0:KEY_POOL_SIZE-1];

    int mismatches = 0;
    int burst_left = 0;
    int gap_left = 0;

    sorted_unique_key_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .op       (op),
        .key      (key),
        .strobe   (strobe),
        .status   (status),
        .key_out  (key_out),
        .position (position),
        .last     (last)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Reset is held low from the start and released once, on a clock edge.
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    task automatic flag_mismatch(input string what);
        $display("[%0t] error: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic queue_reply(input logic [ST_W-1:0] st, input logic signed [KEY_W-1:0] k,
                               input logic [POS_W-1:0] pos, input logic fin);
        reply_t r;
        r.st = st;
        r.k = k;
        r.pos = pos;
        r.fin = fin;
        expected_replies.push_back(r);
    endtask

    // Applies one accepted command to the table model and queues the results it causes.
    // Insert checks for a duplicate before it checks for a full table. Delete, search
    // and list on an empty table give a single empty result. Unused codes do nothing.
    task automatic apply_table_command(input logic [OP_W-1:0] code,
                                       input logic signed [KEY_W-1:0] k);
        int hit;
        int p;
        int src;
        hit = -1;
        for (int i = 0; i < stored_count; i++)
        begin
            if (hit < 0 && model_keys[i] == k)
                hit = i;
        end
        case (code)
            OP_INSERT:
            begin
                if (hit >= 0)
                    queue_reply(ST_DUP, '0, '0, 1'b1);
                else if (stored_count >= TABLE_DEPTH)
                    queue_reply(ST_FULL, '0, '0, 1'b1);
                else
                begin
                    p = 0;
                    while (p < stored_count && model_keys[p] < k)
                        p++;
                    for (int i = stored_count; i > p; i--)
                        model_keys[i] = model_keys[i-1];
                    model_keys[p] = k;
                    stored_count++;
                    queue_reply(ST_OK, '0, '0, 1'b1);
                end
            end
            OP_DELETE, OP_SEARCH:
            begin
                if (stored_count == 0)
                    queue_reply(ST_EMPTY, '0, '0, 1'b1);
                else if (hit < 0)
                    queue_reply(ST_NOTFOUND, '0, '0, 1'b1);
                else if (code == OP_SEARCH)
                    queue_reply(ST_OK, k, '0, 1'b1);
                else
                begin
                    for (int i = hit; i + 1 < stored_count; i++)
                        model_keys[i] = model_keys[i+1];
                    stored_count--;
                    queue_reply(ST_OK, '0, '0, 1'b1);
                end
            end
            OP_LIST_ASC, OP_LIST_DESC:
            begin
                if (stored_count == 0)
                    queue_reply(ST_EMPTY, '0, '0, 1'b1);
                else
                begin
                    for (int i = 0; i < stored_count; i++)
                    begin
                        src = (code == OP_LIST_ASC) ? i : stored_count - 1 - i;
                        queue_reply(ST_OK, model_keys[src], POS_W'(i + 1),
                                    (i + 1 == stored_count));
                    end
                end
            end
            default:
            begin
                // Unused codes are accepted and dropped by the block.
            end
        endcase
    endtask

    task automatic add_command(input logic [OP_W-1:0] code, input logic signed [KEY_W-1:0] k);
        command_t c;
        c.code = code;
        c.value = k;
        pending_commands.push_back(c);
    endtask

    // Mostly keys from the shared pool so that duplicates and hits are common; the
    // rest are fully random so that every key bit toggles.
    function automatic logic signed [KEY_W-1:0] pick_key(input int pool_pct);
        if ($urandom_range(0, 99) < pool_pct)
            return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
        return $urandom;
    endfunction

    // Fills the command queue: a directed opening, then phases that fill the table,
    // mix operations, and drain it again, with a little noise from unused codes.
    initial
    begin
        int issued;
        int phase;
        int roll;
        logic [OP_W-1:0] code;
        key_pool[0] = 32'sh8000_0000;
        key_pool[1] = 32'sh7FFF_FFFF;
        key_pool[2] = 32'sh0000_0000;
        key_pool[3] = -32'sd1;
        for (int i = 4; i < KEY_POOL_SIZE; i++)
            key_pool[i] = $urandom;

        // Empty table first, then the extreme keys and every outcome but a full table.
        add_command(OP_DELETE, 32'sd5);
        add_command(OP_SEARCH, 32'sd5);
        add_command(OP_LIST_ASC, 32'sd0);
        add_command(OP_LIST_DESC, -32'sd1);
        add_command(3'd5, 32'sd1);
        add_command(3'd6, 32'sh7FFF_FFFF);
        add_command(3'd7, 32'sh8000_0000);
        add_command(OP_INSERT, 32'sh7FFF_FFFF);
        add_command(OP_INSERT, 32'sh8000_0000);
        add_command(OP_INSERT, 32'sd0);
        add_command(OP_INSERT, -32'sd1);
        add_command(OP_INSERT, 32'sd1);
        add_command(OP_INSERT, 32'sh8000_0000);
        add_command(OP_SEARCH, 32'sh8000_0000);
        add_command(OP_SEARCH, 32'sh7FFF_FFFF);
        add_command(OP_SEARCH, 32'sd2);
        add_command(OP_DELETE, 32'sd2);
        add_command(OP_LIST_ASC, 32'sd0);
        add_command(OP_LIST_DESC, 32'sd0);
        add_command(OP_DELETE, 32'sd0);
        add_command(OP_DELETE, 32'sh7FFF_FFFF);
        add_command(OP_LIST_DESC, 32'sd0);
        add_command(OP_INSERT, 32'sd0);

        issued = 0;
        while (issued < RANDOM_COMMANDS)
        begin
            phase = (issued / 70) % 3;
            roll = $urandom_range(0, 99);
            if (roll < 4)
                code = 3'($urandom_range(5, 7));
            else if (phase == 0)
                code = (roll < 75) ? OP_INSERT : (roll < 85) ? OP_SEARCH :
                       (roll < 92) ? OP_DELETE : (roll < 96) ? OP_LIST_ASC : OP_LIST_DESC;
            else if (phase == 1)
                code = (roll < 35) ? OP_INSERT : (roll < 60) ? OP_SEARCH :
                       (roll < 85) ? OP_DELETE : (roll < 93) ? OP_LIST_ASC : OP_LIST_DESC;
            else
                code = (roll < 15) ? OP_INSERT : (roll < 30) ? OP_SEARCH :
                       (roll < 88) ? OP_DELETE : (roll < 94) ? OP_LIST_ASC : OP_LIST_DESC;
            add_command(code, pick_key(85));
            if (code <= OP_LIST_DESC)
                issued++;
        end
    end

    // Driver: offers the next command whenever the previous one is gone, in bursts of
    // random length separated by random gaps. The model is updated at the accepting edge.
    always @(posedge clk)
    begin
        command_t c;
        if (rst_n)
        begin
            if (start && !busy)
                apply_table_command(op, key);
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_commands.size() > 0)
                begin
                    c = pending_commands.pop_front();
                    start <= 1'b1;
                    op <= c.code;
                    key <= c.value;
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 16);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 5);
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: every strobe must match the oldest predicted result field by field.
    always @(posedge clk)
    begin
        reply_t r;
        if (rst_n && strobe)
        begin
            if (expected_replies.size() == 0)
                flag_mismatch($sformatf("unexpected result status=%0d key_out=%0d",
                                        status, key_out));
            else
            begin
                r = expected_replies.pop_front();
                if (status !== r.st)
                    flag_mismatch($sformatf("status %0d, predicted %0d", status, r.st));
                if (key_out !== r.k)
                    flag_mismatch($sformatf("key_out %0d, predicted %0d", key_out, r.k));
                if (position !== r.pos)
                    flag_mismatch($sformatf("position %0d, predicted %0d", position, r.pos));
                if (last !== r.fin)
                    flag_mismatch($sformatf("last %0b, predicted %0b", last, r.fin));
            end
        end
    end

    // End of run: all commands accepted, all results in, then a listing's worth of
    // quiet cycles in case the block emits something extra.
    initial
    begin
        @(posedge rst_n);
        @(posedge clk);
        while (pending_commands.size() != 0 || start || busy || expected_replies.size() != 0)
            @(posedge clk);
        repeat (TABLE_DEPTH + 10) @(posedge clk);
        if (mismatches == 0 && expected_replies.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog, about ten times the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
